// ===== rtl/afs_pkg.sv =====
// Shared widths, codes and types for the animation frame sequencer.
package afs_pkg;

    localparam int SLOT_W      = 4;
    localparam int FRAME_IDX_W = 8;
    localparam int PEND_IDX_W  = 9;
    localparam int TOTAL_W     = 9;
    localparam int PERIOD_W    = 16;
    localparam int CHAIN_W     = 5;
    localparam int ELAPSED_W   = 16;
    localparam int WEIGHT_W    = 17;
    localparam int ACC_W       = 32;
    localparam int INC_W       = 23;
    localparam int DIV_W       = 16;
    localparam int STEP_W      = 5;

    localparam int REF_RATE       = 120;
    localparam int DEF_ANIM_SLOTS = 16;
    localparam int DEF_MAX_FRAMES = 256;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic [TOTAL_W-1:0]  total;
        logic [PERIOD_W-1:0] period;
        logic [CHAIN_W-1:0]  chain;
        logic                loops;
    } desc_t;

    typedef struct packed {
        logic              go;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  rem_init;
        logic [DIV_W-1:0]  bits;
        logic [DIV_W-1:0]  divisor;
    } div_cmd_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } div_rsp_t;

endpackage

// ===== rtl/afs_table.sv =====
// Descriptor memory with per-entry valid bits; invalid entries read as zero.
module afs_table
    import afs_pkg::*;
#(
    parameter int DEPTH = DEF_ANIM_SLOTS,
    parameter int AW    = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  desc_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output desc_t         rdata
);

    desc_t              mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    desc_t              rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/afs_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
module afs_divider
    import afs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_cmd_t cmd,
    output div_rsp_t rsp
);

    logic              run_reg;
    logic              done_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  bits_reg;
    logic [DIV_W-1:0]  div_reg;
    logic [DIV_W-1:0]  quot_reg;

    logic [DIV_W:0]    trial;
    logic              ge;
    logic [DIV_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, bits_reg[DIV_W-1]};
        ge       = trial >= {1'b0, div_reg};
        rem_next = ge ? DIV_W'(trial - {1'b0, div_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= cmd.steps;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
                if (cnt_reg == STEP_W'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.go)
        begin
            rem_reg  <= cmd.rem_init;
            bits_reg <= cmd.bits;
            div_reg  <= cmd.divisor;
            quot_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg  <= rem_next;
            bits_reg <= {bits_reg[DIV_W-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ===== rtl/animation_frame_sequencer_top.sv =====
// Animation frame sequencer: descriptor table, blend accumulator and tick sequencer.
//
// Usage: one command channel. A beat is taken at a clock edge with start high
// and busy low. opcode 1 writes a descriptor at that edge and leaves busy low,
// so another command may follow in the next cycle. opcode 0 is a time tick:
// busy rises for the whole tick while the sequencer reads the current and
// pending descriptors, updates the accumulator and runs the shared serial
// divider for the blend weight (16 steps, skipped when the frame advances)
// and for the two frame index remainders (8 and 9 steps, the second skipped
// when the slots differ); the divider loop works one bit per cycle. A tick
// where either descriptor is empty returns to idle once both reads are done
// and gives no beat.
// A result beat shows on the result ports for one cycle with strobe high, in
// the cycle where busy has already fallen; the receiver has no way to stall.
// Reset clears every descriptor valid bit (all entries read as empty), the
// slots, the indices (pending index 1) and the accumulator.
module animation_frame_sequencer_top
    import afs_pkg::*;
#(
    parameter int ANIM_SLOTS = DEF_ANIM_SLOTS,
    parameter int MAX_FRAMES = DEF_MAX_FRAMES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [SLOT_W-1:0]           anim_slot,
    input  logic [TOTAL_W-1:0]          frame_total,
    input  logic [PERIOD_W-1:0]         frame_period,
    input  logic signed [CHAIN_W-1:0]   chain_target,
    input  logic                        loops,
    input  logic [ELAPSED_W-1:0]        elapsed,
    output logic                        strobe,
    output logic [SLOT_W-1:0]           from_slot,
    output logic [FRAME_IDX_W-1:0]      from_index,
    output logic [SLOT_W-1:0]           to_slot,
    output logic [FRAME_IDX_W-1:0]      to_index,
    output logic [WEIGHT_W-1:0]         weight
);

    localparam int AW = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RDF  = 4'd1;
    localparam logic [3:0] S_RDT  = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MODF = 4'd5;
    localparam logic [3:0] S_MODT = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    logic [3:0]             state_reg, state_next;
    logic [SLOT_W-1:0]      cur_slot_reg, pend_slot_reg;
    logic [FRAME_IDX_W-1:0] cur_idx_reg;
    logic [PEND_IDX_W-1:0]  pend_idx_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [INC_W-1:0]       inc_reg;
    desc_t                  from_desc_reg, to_desc_reg;
    logic                   adv_reg;
    logic [WEIGHT_W-1:0]    weight_calc_reg;
    logic [FRAME_IDX_W-1:0] from_idx_reg, to_idx_reg;

    logic                   strobe_reg;
    logic [SLOT_W-1:0]      out_from_slot_reg, out_to_slot_reg;
    logic [FRAME_IDX_W-1:0] out_from_idx_reg, out_to_idx_reg;
    logic [WEIGHT_W-1:0]    out_weight_reg;

    logic                   accept;
    logic                   tbl_we, tbl_re;
    logic [AW-1:0]          tbl_raddr;
    desc_t                  tbl_wdata, tbl_rdata;
    div_cmd_t               div_cmd;
    div_rsp_t               div_rsp;

    logic [TOTAL_W-1:0]     total_sat;
    logic [ACC_W:0]         acc_sum;
    logic [ACC_W-1:0]       acc_sat;
    logic [PERIOD_W-1:0]    p_eff;
    logic                   adv_calc;
    logic                   empty_hit;

    logic                   changed;
    logic [PEND_IDX_W-1:0]  step_idx;
    logic [PEND_IDX_W-1:0]  last_idx;
    logic                   chain_ok;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // descriptor write path
    always_comb
    begin
        total_sat = (32'(frame_total) > MAX_FRAMES) ? TOTAL_W'(MAX_FRAMES) : frame_total;
        tbl_wdata.total  = total_sat;
        tbl_wdata.period = frame_period;
        tbl_wdata.chain  = chain_target;
        tbl_wdata.loops  = loops;
        tbl_we = accept && (opcode == OP_WRITE) && (32'(anim_slot) < ANIM_SLOTS);
    end

    always_comb
    begin
        tbl_re    = 1'b0;
        tbl_raddr = AW'(cur_slot_reg);
        if (accept && (opcode == OP_TICK))
        begin
            tbl_re = 1'b1;
        end
        else if (state_reg == S_RDF)
        begin
            tbl_re    = 1'b1;
            tbl_raddr = AW'(pend_slot_reg);
        end
    end

    afs_table #(
        .DEPTH (ANIM_SLOTS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (tbl_we),
        .waddr (AW'(anim_slot)),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    afs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        acc_sum   = {1'b0, acc_reg} + (ACC_W + 1)'(inc_reg);
        acc_sat   = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
        p_eff     = (from_desc_reg.period == '0) ? PERIOD_W'(256) : from_desc_reg.period;
        adv_calc  = acc_reg >= {8'd0, p_eff, 8'd0};
        empty_hit = (from_desc_reg.total == '0) || (tbl_rdata.total == '0);
    end

    // advance: the new current slot is the pending one, whose descriptor is to_desc_reg
    always_comb
    begin
        changed  = (cur_slot_reg != pend_slot_reg);
        step_idx = changed ? PEND_IDX_W'(1) : PEND_IDX_W'(pend_idx_reg + PEND_IDX_W'(1));
        last_idx = to_desc_reg.total - TOTAL_W'(1);
        chain_ok = !to_desc_reg.chain[CHAIN_W-1]
                   && (32'(to_desc_reg.chain[CHAIN_W-2:0]) < ANIM_SLOTS);
    end

    always_comb
    begin
        state_next       = state_reg;
        div_cmd.go       = 1'b0;
        div_cmd.steps    = STEP_W'(16);
        div_cmd.rem_init = acc_reg[23:8];
        div_cmd.bits     = {acc_reg[7:0], 8'd0};
        div_cmd.divisor  = p_eff;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (opcode == OP_TICK))
                begin
                    state_next = S_RDF;
                end
            end
            S_RDF:
            begin
                state_next = S_RDT;
            end
            S_RDT:
            begin
                state_next = empty_hit ? S_IDLE : S_CMP;
            end
            S_CMP:
            begin
                div_cmd.go = 1'b1;
                if (adv_calc)
                begin
                    div_cmd.steps    = STEP_W'(FRAME_IDX_W);
                    div_cmd.rem_init = '0;
                    div_cmd.bits     = {cur_idx_reg, 8'd0};
                    div_cmd.divisor  = DIV_W'(from_desc_reg.total);
                    state_next       = S_MODF;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    div_cmd.go       = 1'b1;
                    div_cmd.steps    = STEP_W'(FRAME_IDX_W);
                    div_cmd.rem_init = '0;
                    div_cmd.bits     = {cur_idx_reg, 8'd0};
                    div_cmd.divisor  = DIV_W'(from_desc_reg.total);
                    state_next       = S_MODF;
                end
            end
            S_MODF:
            begin
                if (div_rsp.done)
                begin
                    if (!changed)
                    begin
                        div_cmd.go       = 1'b1;
                        div_cmd.steps    = STEP_W'(PEND_IDX_W);
                        div_cmd.rem_init = '0;
                        div_cmd.bits     = {pend_idx_reg, 7'd0};
                        div_cmd.divisor  = DIV_W'(from_desc_reg.total);
                        state_next       = S_MODT;
                    end
                    else
                    begin
                        state_next = S_EMIT;
                    end
                end
            end
            S_MODT:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_slot_reg  <= '0;
            pend_slot_reg <= '0;
            cur_idx_reg   <= '0;
            pend_idx_reg  <= PEND_IDX_W'(1);
            acc_reg       <= '0;
            strobe_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= (state_reg == S_EMIT);
            if (state_reg == S_RDT && !empty_hit)
            begin
                acc_reg <= acc_sat;
            end
            if (state_reg == S_EMIT && adv_reg)
            begin
                acc_reg      <= '0;
                cur_slot_reg <= pend_slot_reg;
                cur_idx_reg  <= changed ? '0 : pend_idx_reg[FRAME_IDX_W-1:0];
                if (step_idx > last_idx)
                begin
                    if (chain_ok)
                    begin
                        pend_idx_reg  <= '0;
                        pend_slot_reg <= SLOT_W'(to_desc_reg.chain[CHAIN_W-2:0]);
                    end
                    else if (to_desc_reg.loops)
                    begin
                        pend_idx_reg <= '0;
                    end
                    else
                    begin
                        pend_idx_reg <= last_idx;
                    end
                end
                else
                begin
                    pend_idx_reg <= step_idx;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            inc_reg <= INC_W'(elapsed) * INC_W'(REF_RATE);
        end
        if (state_reg == S_RDF)
        begin
            from_desc_reg <= tbl_rdata;
        end
        if (state_reg == S_RDT)
        begin
            to_desc_reg <= tbl_rdata;
        end
        if (state_reg == S_CMP)
        begin
            adv_reg         <= adv_calc;
            weight_calc_reg <= WEIGHT_ONE;
        end
        if (state_reg == S_DIV && div_rsp.done)
        begin
            weight_calc_reg <= {1'b0, div_rsp.quot};
        end
        if (state_reg == S_MODF && div_rsp.done)
        begin
            from_idx_reg <= div_rsp.rem[FRAME_IDX_W-1:0];
            to_idx_reg   <= '0;
        end
        if (state_reg == S_MODT && div_rsp.done)
        begin
            to_idx_reg <= div_rsp.rem[FRAME_IDX_W-1:0];
        end
        if (state_reg == S_EMIT)
        begin
            out_from_slot_reg <= cur_slot_reg;
            out_from_idx_reg  <= from_idx_reg;
            out_to_slot_reg   <= pend_slot_reg;
            out_to_idx_reg    <= to_idx_reg;
            out_weight_reg    <= weight_calc_reg;
        end
    end

    assign strobe     = strobe_reg;
    assign from_slot  = out_from_slot_reg;
    assign from_index = out_from_idx_reg;
    assign to_slot    = out_to_slot_reg;
    assign to_index   = out_to_idx_reg;
    assign weight     = out_weight_reg;

    // a result beat only appears once the tick has finished
    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> !busy)
        else $error("result beat while busy");

    a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |=> !strobe)
        else $error("two result beats in a row");

    a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> (weight <= WEIGHT_ONE))
        else $error("weight above unity");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_TICK)) |=> busy)
        else $error("tick accepted without going busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_WRITE)) |=> (!busy && !strobe))
        else $error("descriptor write started a tick");

endmodule
